/* hw/rtl/acs_pkg.sv */
// Package: widths, per-channel record type and sequencer states for the ADC statistics unit.
`timescale 1ns / 1ps
package acs_pkg;

  localparam int CHAN_W       = 2;
  localparam int NUM_CHANNELS = 4;
  localparam int CODE_W       = 12;
  localparam int CNT_W        = 11;
  localparam int FLT_W        = 12;
  localparam int SUM_W        = 22;
  localparam int SQ_W         = 34;
  localparam int MAX_SAMPLES  = 1024;
  localparam int MEAN_W       = 20;
  localparam int SD_W         = 19;
  localparam int PROD_W       = CNT_W + SQ_W;
  localparam int NN_W         = 2 * CNT_W;
  localparam int DIVD_W       = 64;
  localparam int DIVS_W       = 21;
  localparam int QUOT_W       = 40;
  localparam int ROOT_W       = QUOT_W / 2;
  localparam int CFG_ADDR_W   = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_OVER_LIMIT  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_UNDER_LIMIT = 1'b1;

  localparam logic [CODE_W-1:0] OVER_LIMIT_RST  = 12'd3722;
  localparam logic [CODE_W-1:0] UNDER_LIMIT_RST = 12'd373;

  typedef struct packed {
    logic              ovf;
    logic [CODE_W-1:0] max_code;
    logic [CODE_W-1:0] min_code;
    logic [SQ_W-1:0]   sq;
    logic [SUM_W-1:0]  sum;
    logic [FLT_W-1:0]  flt;
    logic [CNT_W-1:0]  cnt;
  } chan_stats_t;

  localparam int STATS_W = $bits(chan_stats_t);

  localparam chan_stats_t STATS_RESET = '{
    ovf: 1'b0, max_code: '0, min_code: {CODE_W{1'b1}}, sq: '0, sum: '0, flt: '0, cnt: '0
  };

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_RD, S_LD, S_MUL, S_DEV, S_MEAN, S_VAR, S_SQRT, S_OUT
  } acs_state_e;

endpackage

/* hw/rtl/adc_channel_statistics_unit.sv */
// Top level: per-channel ADC sample statistics with batch report.
`timescale 1ns / 1ps
// A sample's channel record is read from the stats RAM, then updated and
// written back; the input is not ready again until the write-back is done.
// After a sample marked tlast, one report per channel follows in channel
// order; a channel with samples passes twice through the shared divider,
// for mean and variance, then through the square root, while an empty
// channel goes straight from its record read to the output.
// No samples are taken during the report. A finished report waits in the
// output register; stats are cleared once the last report is loaded.
module adc_channel_statistics_unit
  import acs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // chan, raw_code
  input  logic                  s_axis_tuser,  // probe_fault
  input  logic                  s_axis_tlast,  // batch_last
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [87:0]           m_axis_tdata,  // out_chan, sample_total, fault_total,
                                               // mean_q8, min_code, max_code, stddev_q8
  output logic [1:0]            m_axis_tuser,  // count_saturated, channel_empty
  output logic                  m_axis_tlast,  // report_last
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CODE_W-1:0]     cfg_wdata_i
);

  acs_state_e state_q, state_d;

  logic [CODE_W-1:0]       over_q, under_q;
  logic [NUM_CHANNELS-1:0] vld_q;
  logic [CHAN_W-1:0]       sch_q, rch_q;
  logic [CODE_W-1:0]       code_q;
  logic                    sflt_q, slast_q;
  logic [2*CODE_W-1:0]     code_sq;

  chan_stats_t       st_q, cur, upd;
  logic [STATS_W-1:0] ram_rdata;
  logic [CHAN_W-1:0]  ram_raddr;
  logic               ram_we;

  logic [PROD_W-1:0] prod_q, dev_q;
  logic [2*SUM_W-1:0] ss_q;
  logic [NN_W-1:0]   nn_q;
  logic [MEAN_W-1:0] mean_q;
  logic [SD_W-1:0]   sd_q;

  logic              div_start, div_busy, div_done;
  logic [DIVD_W-1:0] div_dvd;
  logic [DIVS_W-1:0] div_dvs;
  logic [QUOT_W-1:0] div_quot;
  logic              sq_start, sq_done;
  logic [ROOT_W-1:0] sq_root;

  logic out_load, out_vld_q, rpt_last, empty;
  logic [1:0] flt_inc;

  acs_ram #(.Width(STATS_W), .Depth(NUM_CHANNELS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sch_q),
    .wdata_i (upd),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  acs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  acs_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (div_quot),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  // record as read back; an entry not written since the last clear is fresh
  always_comb begin
    cur = vld_q[state_q == S_UPD ? sch_q : rch_q] ? chan_stats_t'(ram_rdata) : STATS_RESET;
    upd = cur;
    code_sq = code_q * code_q;
    flt_inc = 2'(code_q > over_q) + 2'(code_q < under_q) + 2'(sflt_q);
    if (cur.cnt == CNT_W'(MAX_SAMPLES)) begin
      upd.ovf = 1'b1;
    end else begin
      upd.cnt = cur.cnt + 1'b1;
      upd.sum = cur.sum + SUM_W'(code_q);
      upd.sq  = cur.sq + SQ_W'(code_sq);
      upd.flt = cur.flt + FLT_W'(flt_inc);
      if (code_q < cur.min_code) upd.min_code = code_q;
      if (code_q > cur.max_code) upd.max_code = code_q;
    end
  end

  assign empty    = (st_q.cnt == '0);
  assign rpt_last = (rch_q == CHAN_W'(NUM_CHANNELS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_UPD;
      S_UPD:  state_d = slast_q ? S_RD : S_IDLE;
      S_RD:   state_d = S_LD;
      S_LD:   state_d = (cur.cnt == '0) ? S_OUT : S_MUL;
      S_MUL:  state_d = S_DEV;
      S_DEV:  state_d = S_MEAN;
      S_MEAN: if (div_done) state_d = S_VAR;
      S_VAR:  if (div_done) state_d = S_SQRT;
      S_SQRT: if (sq_done) state_d = S_OUT;
      S_OUT:  if (out_load) state_d = rpt_last ? S_IDLE : S_RD;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = rch_q;
    div_start = 1'b0;
    div_dvd   = {{(DIVD_W-SUM_W-8){1'b0}}, st_q.sum, 8'b0};
    div_dvs   = DIVS_W'(st_q.cnt);
    sq_start  = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        ram_raddr = s_axis_tdata[CHAN_W-1:0];
      end
      S_UPD:  ram_we = 1'b1;
      S_MUL:  div_start = 1'b1;
      S_MEAN: begin
        div_start = div_done;
        div_dvd   = {{(DIVD_W-PROD_W-16){1'b0}}, dev_q, 16'b0};
        div_dvs   = nn_q[DIVS_W-1:0];
      end
      S_VAR:  sq_start = div_done;
      S_OUT:  out_load = !out_vld_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      over_q    <= OVER_LIMIT_RST;
      under_q   <= UNDER_LIMIT_RST;
      vld_q     <= '0;
      rch_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_OVER_LIMIT:  over_q  <= cfg_wdata_i;
          REG_UNDER_LIMIT: under_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (ram_we) vld_q[sch_q] <= 1'b1;
      if (state_q == S_UPD && slast_q) rch_q <= '0;
      if (out_load) begin
        if (rpt_last) vld_q <= '0;
        else rch_q <= rch_q + 1'b1;
      end
      if (out_load) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sch_q   <= s_axis_tdata[CHAN_W-1:0];
      code_q  <= s_axis_tdata[CHAN_W +: CODE_W];
      sflt_q  <= s_axis_tuser;
      slast_q <= s_axis_tlast;
    end
    if (state_q == S_LD) st_q <= cur;
    if (state_q == S_MUL) begin
      prod_q <= st_q.cnt * st_q.sq;
      ss_q   <= st_q.sum * st_q.sum;
      nn_q   <= st_q.cnt * st_q.cnt;
    end
    if (state_q == S_DEV) dev_q <= prod_q - PROD_W'(ss_q);
    if (state_q == S_MEAN && div_done) mean_q <= div_quot[MEAN_W-1:0];
    if (state_q == S_SQRT && sq_done) sd_q <= sq_root[SD_W-1:0];
    if (out_load) begin
      m_axis_tlast <= rpt_last;
      if (empty) begin
        m_axis_tdata <= {86'b0, rch_q};
        m_axis_tuser <= 2'b10;
      end else begin
        m_axis_tdata <= {sd_q, st_q.max_code, st_q.min_code, mean_q,
                         st_q.flt, st_q.cnt, rch_q};
        m_axis_tuser <= {1'b0, st_q.ovf};
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;

`ifndef SYNTHESIS
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider started while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_vld_q || m_axis_tready)) else $error("report overwritten");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && rpt_last) |=> (vld_q == '0)) else $error("stats not cleared");
`endif

endmodule

/* hw/rtl/acs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module acs_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/acs_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module acs_div
  import acs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  localparam int STEP_W = $clog2(DIVD_W);

  logic              busy_q, busy_d, done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DIVD_W-1:0] dvd_q, dvd_d;
  logic [DIVS_W-1:0] dvs_q, dvs_d;
  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [QUOT_W-1:0] quo_q, quo_d;
  logic [DIVS_W:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    trial  = {rem_q, dvd_q[DIVD_W-1]};
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DIVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DIVS_W'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[QUOT_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIVS_W-1:0];
        quo_d = {quo_q[QUOT_W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(DIVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* hw/rtl/acs_sqrt.sv */
// Digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module acs_sqrt
  import acs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [QUOT_W-1:0] radicand_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int REM_W  = ROOT_W + 4;
  localparam int STEP_W = $clog2(ROOT_W);

  logic              busy_q, busy_d, done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [QUOT_W-1:0] rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W-1:0]  cur, trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cur    = {rem_q[REM_W-3:0], rad_q[QUOT_W-1 -: 2]};
    trial  = {2'b00, root_q, 2'b01};
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      step_d = '0;
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[QUOT_W-3:0], 2'b00};
      if (cur >= trial) begin
        rem_d  = cur - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = cur;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(ROOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* sim/adc_channel_statistics_checker.sv */
// Checker: predicts per-channel batch reports from observed samples and compares them.
`timescale 1ns / 1ps
module adc_channel_statistics_checker
  import acs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [87:0]           m_axis_tdata,
  input  logic [1:0]            m_axis_tuser,
  input  logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CODE_W-1:0]     cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic              last;
    logic [1:0]        user;
    logic [87:0]       data;
  } report_t;

  report_t             report_q[$];
  logic [CODE_W-1:0]   over_lim, under_lim;
  logic [63:0]         cnt[NUM_CHANNELS], flt[NUM_CHANNELS], sum[NUM_CHANNELS];
  logic [63:0]         sq[NUM_CHANNELS], mn[NUM_CHANNELS], mx[NUM_CHANNELS];
  logic                ovf[NUM_CHANNELS];

  assign pending_o = report_q.size();

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  task automatic clear_channels();
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      cnt[c] = 0; flt[c] = 0; sum[c] = 0; sq[c] = 0;
      mn[c] = 4095; mx[c] = 0; ovf[c] = 0;
    end
  endtask

  task automatic take_sample(logic [1:0] ch, logic [11:0] code, logic sf, logic lst);
    logic [63:0] n, s, dev, nn, var_q16;
    report_t     r;
    if (cnt[ch] >= MAX_SAMPLES) begin
      ovf[ch] = 1;
    end else begin
      cnt[ch] += 1;
      sum[ch] += code;
      sq[ch] += 64'(code) * 64'(code);
      if (code < mn[ch]) mn[ch] = code;
      if (code > mx[ch]) mx[ch] = code;
      if (code > over_lim) flt[ch] += 1;
      if (code < under_lim) flt[ch] += 1;
      if (sf) flt[ch] += 1;
    end
    if (!lst) return;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      n = cnt[c];
      r = '0;
      r.last = (c == NUM_CHANNELS - 1);
      r.data[1:0] = c[1:0];
      if (n == 0) begin
        r.user[1] = 1'b1;
      end else begin
        s = sum[c];
        nn = n * n;
        dev = n * sq[c] - s * s;
        var_q16 = ((dev / nn) << 16) + (((dev % nn) << 16) / nn);
        r.data = {SD_W'(int_sqrt(var_q16)), CODE_W'(mx[c]), CODE_W'(mn[c]),
                  MEAN_W'((s << 8) / n), FLT_W'(flt[c]), CNT_W'(n), c[1:0]};
        r.user = {1'b0, ovf[c]};
      end
      report_q.push_back(r);
    end
    clear_channels();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    report_t e;
    if (!rst_ni) begin
      over_lim = OVER_LIMIT_RST;
      under_lim = UNDER_LIMIT_RST;
      clear_channels();
      report_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_OVER_LIMIT) over_lim = cfg_wdata_i;
        else under_lim = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready)
        take_sample(s_axis_tdata[1:0], s_axis_tdata[13:2], s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (report_q.size() == 0) begin
          $display("%0t: unexpected report data %h user %b last %b", $time,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fail_count_o++;
        end else begin
          e = report_q.pop_front();
          if (e.data !== m_axis_tdata || e.user !== m_axis_tuser
              || e.last !== m_axis_tlast) begin
            $display("%0t: mismatch expected data %h user %b last %b", $time,
                     e.data, e.user, e.last);
            $display("%0t:          actual   data %h user %b last %b", $time,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

/* sim/adc_channel_statistics_unit_tb.sv */
// Testbench top: stimulus, configuration phases and verdict for the ADC statistics unit.
`timescale 1ns / 1ps
module adc_channel_statistics_unit_tb;
  import acs_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0, s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0, s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid, m_axis_tready = 1'b0;
  logic [87:0]           m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CODE_W-1:0]     cfg_wdata_i = '0;
  int                    fail_count, pending;
  int                    send_idle_pct = 0, recv_stall_pct = 0;
  bit                    hold_off = 1'b0;

  always #5 clk_i = ~clk_i;

  adc_channel_statistics_unit dut (.*);

  adc_channel_statistics_checker u_checker (
    .fail_count_o(fail_count), .pending_o(pending), .*
  );

  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_sample(logic [1:0] ch, logic [11:0] code, logic sf, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, code, ch};
    s_axis_tuser <= sf;
    s_axis_tlast <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic stop_input();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CODE_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_batch(int len);
    logic [11:0] code;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(3))
        0: code = 12'($urandom_range(4095));
        1: code = 12'($urandom_range(40));
        2: code = 12'(4095 - $urandom_range(40));
        default: code = 12'(2048 + $urandom_range(255));
      endcase
      send_sample(2'($urandom_range(3)), code, ($urandom_range(7) == 0), i == len - 1);
    end
  endtask

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, faults, empty channels, single-sample batch
    send_sample(2'd0, 12'd0, 1'b0, 1'b0);
    send_sample(2'd0, 12'd4095, 1'b1, 1'b0);
    send_sample(2'd1, 12'd3722, 1'b0, 1'b0);
    send_sample(2'd1, 12'd3723, 1'b0, 1'b0);
    send_sample(2'd1, 12'd373, 1'b0, 1'b0);
    send_sample(2'd1, 12'd372, 1'b1, 1'b1);
    send_sample(2'd3, 12'd2048, 1'b0, 1'b1);
    send_sample(2'd2, 12'd4095, 1'b1, 1'b0);
    send_sample(2'd2, 12'd4095, 1'b0, 1'b1);
    stop_input();
    drain();
    write_reg(REG_OVER_LIMIT, 12'd4095);
    write_reg(REG_UNDER_LIMIT, 12'd0);
    random_batch(10);
    stop_input();
    drain();
    write_reg(REG_OVER_LIMIT, 12'd0);
    write_reg(REG_UNDER_LIMIT, 12'd4095);
    random_batch(10);
    stop_input();
    drain();
    write_reg(REG_OVER_LIMIT, 12'd2000);
    write_reg(REG_UNDER_LIMIT, 12'd1000);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 47 : 12) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 47 : 12) : 0;
      for (int b = 0; b < 6; b++) random_batch($urandom_range(1, 20));
    end
    // long receiver hold-off while batches keep coming
    hold_off = 1'b1;
    fork
      begin
        for (int b = 0; b < 4; b++) random_batch($urandom_range(1, 4));
        stop_input();
      end
      begin
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
